FILE: rtl/twf_pkg.sv
// twf_pkg: shared widths, register indexes and pipeline record types
// for the triangle wind force block; no dependencies
package twf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SQRT_N    = 32;  // one root bit per stage
  localparam int unsigned DIV_N     = 34;  // one quotient bit per stage

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIND_X = 2'd0,
    REG_WIND_Y = 2'd1,
    REG_WIND_Z = 2'd2
  } cfg_reg_e;

  // side data that travels with an item through the root and divide stages
  typedef struct packed {
    logic [2:0][30:0]   m;      // scaled normal, signed per component
    logic signed [6:0]  k;      // block scale exponent
    logic               degen;  // zero-length normal
  } carry_t;

  typedef struct packed {
    logic [63:0]        x;
    logic [63:0]        r;
    logic signed [63:0] dot;
    carry_t             c;
  } sqrt_rec_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [33:0] low;
    logic [33:0] quo;
    logic [30:0] den;
    logic        neg;
    carry_t      c;
  } div_rec_t;

endpackage

FILE: rtl/twf_tri_if.sv
// twf_tri_if: input channel carrying the three triangle corners
// depends on twf_pkg
interface twf_tri_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [twf_pkg::DATA_W-1:0]    a_x;
  logic signed [twf_pkg::DATA_W-1:0]    a_y;
  logic signed [twf_pkg::DATA_W-1:0]    a_z;
  logic signed [twf_pkg::DATA_W-1:0]    b_x;
  logic signed [twf_pkg::DATA_W-1:0]    b_y;
  logic signed [twf_pkg::DATA_W-1:0]    b_z;
  logic signed [twf_pkg::DATA_W-1:0]    c_x;
  logic signed [twf_pkg::DATA_W-1:0]    c_y;
  logic signed [twf_pkg::DATA_W-1:0]    c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

FILE: rtl/twf_force_if.sv
// twf_force_if: output channel carrying the force and status flags
// depends on twf_pkg
interface twf_force_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [twf_pkg::DATA_W-1:0]    force_x;
  logic signed [twf_pkg::DATA_W-1:0]    force_y;
  logic signed [twf_pkg::DATA_W-1:0]    force_z;
  logic                                 degenerate;
  logic                                 clipped;

  modport source (output valid, force_x, force_y, force_z, degenerate, clipped,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, degenerate, clipped,
                output ready);
endinterface

FILE: rtl/triangle_wind_force_top.sv
// triangle_wind_force_top: pipelined wind force on one cloth triangle
// depends on twf_pkg, twf_tri_if, twf_force_if
//
// usage
//   tri_i carries the corners a, b, c of one triangle (signed Q16.16); a
//   transfer happens when valid and ready are both high. force_o returns
//   f = n * (n.d)/|n| for n = (c-a) x (b-a), saturated to Q16.16, with
//   degenerate (zero normal, force zero) and clipped flags.
//   The wind vector d is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while no triangle is in flight; indexes 0..2 select x, y, z.
// pipeline
//   from input transfer to result valid an item passes the edge, cross
//   product, scaling and dot product stages, 32 integer square root
//   stages, 1 + 34 divide stages and the scaling and saturation stages.
//   one triangle is taken every cycle while force_o does not stall; the
//   root and divide pipelines retire one bit per stage.
// reset and stall
//   rst_ni clears all valid bits and the wind registers to zero.
//   when force_o stalls with a result waiting, the whole pipeline holds
//   and tri_i.ready drops; nothing is lost or repeated.
module triangle_wind_force_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  twf_tri_if.sink                           tri_i,
  twf_force_if.source                       force_o,
  input  logic                              cfg_we_i,
  input  logic [twf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [twf_pkg::DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned SQ_N = twf_pkg::SQRT_N;
  localparam int unsigned DV_N = twf_pkg::DIV_N;

  // pipeline advance
  logic en;
  logic out_v_q;
  assign en          = !out_v_q || force_o.ready;
  assign tri_i.ready = en;

  // wind registers
  logic signed [31:0] wind_x_q, wind_y_q, wind_z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wind_x_q <= '0;
      wind_y_q <= '0;
      wind_z_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == twf_pkg::REG_WIND_X) wind_x_q <= cfg_data_i;
      if (cfg_idx_i == twf_pkg::REG_WIND_Y) wind_y_q <= cfg_data_i;
      if (cfg_idx_i == twf_pkg::REG_WIND_Z) wind_z_q <= cfg_data_i;
    end
  end

  // valid bits of the front stages
  logic [6:0] fv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[5:0], tri_i.valid};
    end
  end

  // stage 1: edges u = c - a, v = b - a
  logic signed [32:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= 33'(tri_i.c_x) - 33'(tri_i.a_x);
      uy_q <= 33'(tri_i.c_y) - 33'(tri_i.a_y);
      uz_q <= 33'(tri_i.c_z) - 33'(tri_i.a_z);
      vx_q <= 33'(tri_i.b_x) - 33'(tri_i.a_x);
      vy_q <= 33'(tri_i.b_y) - 33'(tri_i.a_y);
      vz_q <= 33'(tri_i.b_z) - 33'(tri_i.a_z);
    end
  end

  // stage 2: cross product partial products
  logic signed [65:0] cp_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= uy_q * vz_q;
      cp_q[1] <= uz_q * vy_q;
      cp_q[2] <= uz_q * vx_q;
      cp_q[3] <= ux_q * vz_q;
      cp_q[4] <= ux_q * vy_q;
      cp_q[5] <= uy_q * vx_q;
    end
  end

  // stage 3: normal components as sign and magnitude
  logic [2:0][65:0]   nmag_d, nmag_q;
  logic [2:0]         nneg_d, nneg_q;
  always_comb begin
    logic signed [66:0] n;
    for (int i = 0; i < 3; i++) begin
      n         = 67'(cp_q[2*i]) - 67'(cp_q[2*i+1]);
      nneg_d[i] = n[66];
      nmag_d[i] = n[66] ? 66'(-n) : n[65:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      nmag_q <= nmag_d;
      nneg_q <= nneg_d;
    end
  end

  // stage 4: bit length of the largest component
  logic [6:0]       len_d, len_q;
  logic [2:0][65:0] nmag4_q;
  logic [2:0]       nneg4_q;
  always_comb begin
    logic [65:0] any;
    any   = nmag_q[0] | nmag_q[1] | nmag_q[2];
    len_d = '0;
    for (int i = 0; i < 66; i++) begin
      if (any[i]) len_d = 7'(i + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q   <= len_d;
      nmag4_q <= nmag_q;
      nneg4_q <= nneg_q;
    end
  end

  // stage 5: block scaling to 30 bits of magnitude
  twf_pkg::carry_t sc_d, sc_q;
  always_comb begin
    logic signed [7:0] k;
    logic [65:0]       sh;
    k        = $signed({1'b0, len_q}) - 8'sd30;
    sc_d.k   = k[6:0];
    sc_d.degen = (len_q == '0);
    for (int i = 0; i < 3; i++) begin
      if (k > 0) sh = nmag4_q[i] >> k[5:0];
      else       sh = nmag4_q[i] << 6'(-k);
      sc_d.m[i] = nneg4_q[i] ? 31'(-{1'b0, sh[29:0]}) : {1'b0, sh[29:0]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) sc_q <= sc_d;
  end

  // stage 6: squares and wind products
  logic [2:0][59:0]          sqr_q;
  logic signed [62:0]        wp_q [3];
  twf_pkg::carry_t           c6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= 60'(62'($signed(sc_q.m[i])) * 62'($signed(sc_q.m[i])));
      end
      wp_q[0] <= $signed(sc_q.m[0]) * wind_x_q;
      wp_q[1] <= $signed(sc_q.m[1]) * wind_y_q;
      wp_q[2] <= $signed(sc_q.m[2]) * wind_z_q;
      c6_q    <= sc_q;
    end
  end

  // stage 7: sum of squares and dot product, root pipeline entry
  twf_pkg::sqrt_rec_t sq_q [SQ_N+1];
  twf_pkg::sqrt_rec_t sq_d [SQ_N];
  logic [SQ_N:0]      sqv_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].x   <= 64'(sqr_q[0]) + 64'(sqr_q[1]) + 64'(sqr_q[2]);
      sq_q[0].r   <= '0;
      sq_q[0].dot <= 64'(wp_q[0]) + 64'(wp_q[1]) + 64'(wp_q[2]);
      sq_q[0].c   <= c6_q;
    end
  end
  assign sqv_q[0] = fv_q[6];

  // integer square root, one result bit per stage
  for (genvar gi = 0; gi < SQ_N; gi++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * gi);
    always_comb begin
      logic [63:0] trial;
      sq_d[gi] = sq_q[gi];
      trial    = sq_q[gi].r + BIT;
      if (sq_q[gi].x >= trial) begin
        sq_d[gi].x = sq_q[gi].x - trial;
        sq_d[gi].r = (sq_q[gi].r >> 1) + BIT;
      end else begin
        sq_d[gi].r = sq_q[gi].r >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[gi+1] <= 1'b0;
      end else if (en) begin
        sqv_q[gi+1] <= sqv_q[gi];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[gi+1] <= sq_d[gi];
    end
  end

  // divide entry: magnitude of the dot product over the root
  twf_pkg::div_rec_t dv_q [DV_N+1];
  twf_pkg::div_rec_t dv0_d;
  logic [DV_N:0]     dvv_q;
  always_comb begin
    logic [63:0] dmag;
    dmag = sq_q[SQ_N].dot[63] ? 64'(-sq_q[SQ_N].dot) : sq_q[SQ_N].dot;
    dv0_d.rem = 31'(dmag[62:34]);
    dv0_d.low = dmag[33:0];
    dv0_d.quo = '0;
    dv0_d.den = sq_q[SQ_N].r[30:0];
    dv0_d.neg = sq_q[SQ_N].dot[63];
    dv0_d.c   = sq_q[SQ_N].c;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= sqv_q[SQ_N];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv0_d;
  end

  // restoring divide, one quotient bit per stage
  for (genvar gj = 0; gj < DV_N; gj++) begin : g_div
    twf_pkg::div_rec_t step;
    always_comb begin
      logic [31:0] rem2;
      logic        ge;
      step      = dv_q[gj];
      rem2      = {dv_q[gj].rem, dv_q[gj].low[33]};
      ge        = rem2 >= {1'b0, dv_q[gj].den};
      step.rem  = ge ? 31'(rem2 - {1'b0, dv_q[gj].den}) : rem2[30:0];
      step.low  = {dv_q[gj].low[32:0], 1'b0};
      step.quo  = {dv_q[gj].quo[32:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[gj+1] <= 1'b0;
      end else if (en) begin
        dvv_q[gj+1] <= dvv_q[gj];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[gj+1] <= step;
    end
  end

  // back stages: valid bits
  logic [2:0] bv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[1:0], dvv_q[DV_N]};
    end
  end

  // signed projection t
  logic signed [34:0] t_q;
  twf_pkg::carry_t    ct_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q  <= dv_q[DV_N].neg ? -$signed({1'b0, dv_q[DV_N].quo})
                             : $signed({1'b0, dv_q[DV_N].quo});
      ct_q <= dv_q[DV_N].c;
    end
  end

  // force products m * t and output exponent
  logic signed [65:0] fp_q [3];
  logic signed [6:0]  s_q;
  logic               dg_p_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) fp_q[i] <= $signed(ct_q.m[i]) * t_q;
      s_q    <= ct_q.k - 7'sd32;
      dg_p_q <= ct_q.degen;
    end
  end

  // scale by 2^s with round half away from zero
  logic [2:0][69:0] fv_d, fvs_q;
  logic [2:0]       fn_d, fn_q;
  logic             dg_r_q;
  always_comb begin
    logic [65:0] mag;
    logic [5:0]  r;
    r = 6'(-s_q);
    for (int i = 0; i < 3; i++) begin
      fn_d[i] = fp_q[i][65];
      mag     = fp_q[i][65] ? 66'(-fp_q[i]) : fp_q[i];
      if (!s_q[6]) fv_d[i] = 70'(mag) << s_q[2:0];
      else         fv_d[i] = (70'(mag) + (70'(1) << (r - 6'd1))) >> r;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fvs_q  <= fv_d;
      fn_q   <= fn_d;
      dg_r_q <= dg_p_q;
    end
  end

  // saturation and output register
  logic [2:0][31:0] res_d;
  logic [2:0]       clp_d;
  always_comb begin
    logic [69:0] lim;
    logic [69:0] v;
    for (int i = 0; i < 3; i++) begin
      lim      = fn_q[i] ? (70'(1) << 31) : ((70'(1) << 31) - 70'(1));
      clp_d[i] = fvs_q[i] > lim;
      v        = clp_d[i] ? lim : fvs_q[i];
      res_d[i] = fn_q[i] ? 32'(-v) : v[31:0];
    end
  end

  logic signed [31:0] fx_q, fy_q, fz_q;
  logic               degen_q, clip_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= bv_q[2];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q    <= dg_r_q ? '0 : res_d[0];
      fy_q    <= dg_r_q ? '0 : res_d[1];
      fz_q    <= dg_r_q ? '0 : res_d[2];
      degen_q <= dg_r_q;
      clip_q  <= !dg_r_q && (|clp_d);
    end
  end

  assign force_o.valid      = out_v_q;
  assign force_o.force_x    = fx_q;
  assign force_o.force_y    = fy_q;
  assign force_o.force_z    = fz_q;
  assign force_o.degenerate = degen_q;
  assign force_o.clipped    = clip_q;

endmodule
